FILE: rtl/picb_pkg.sv
// Package: widths, register map and shared types of the periodic interval clock bank.
`default_nettype none
package picb_pkg;
	localparam int TIME_W           = 48;
	localparam int IV_W             = 24;
	localparam int MASK_W           = 4;
	localparam int CFG_IDX_W        = 4;
	localparam int NUM_REGS         = 4;
	localparam int NUM_CHANNELS_DEF = 4;
	localparam int CNT_W            = $clog2(TIME_W);

	typedef struct packed {
		logic load;
		logic step;
	} lane_ctrl_t;
endpackage
`default_nettype wire

FILE: rtl/picb_if.sv
// Interfaces: time sample, result and configuration write channels.
`default_nettype none
interface picb_in_if import picb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] time_ms;
	modport source (output valid, output time_ms, input ready);
	modport sink (input valid, input time_ms, output ready);
endinterface

interface picb_out_if import picb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] fired_mask;
	modport source (output valid, output fired_mask, input ready);
	modport sink (input valid, input fired_mask, output ready);
endinterface

interface picb_cfg_if import picb_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [IV_W-1:0]      data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/picb_lane.sv
// Bit-serial restoring modulo unit: remainder of elapsed time by one channel interval.
`default_nettype none
module picb_lane import picb_pkg::*; (
	input  wire logic              clk,
	input  wire lane_ctrl_t        ctrl,
	input  wire logic [TIME_W-1:0] elapsed,
	input  wire logic [IV_W-1:0]   iv,
	output logic      [IV_W-1:0]   rem
);
	logic [TIME_W-1:0] dvd_q;
	logic [IV_W-1:0]   rem_q;
	logic [IV_W+1:0]   diff;
	logic [IV_W-1:0]   rem_next;

	always_comb begin
		diff = {1'b0, rem_q, dvd_q[TIME_W-1]} - {2'b00, iv};
		if (!diff[IV_W+1]) begin
			rem_next = diff[IV_W-1:0];
		end else begin
			rem_next = {rem_q[IV_W-2:0], dvd_q[TIME_W-1]};
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			dvd_q <= elapsed;
			rem_q <= '0;
		end else if (ctrl.step) begin
			dvd_q <= {dvd_q[TIME_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign rem = rem_q;
endmodule
`default_nettype wire

FILE: rtl/periodic_interval_clock_bank_core.sv
// Top level: periodic interval clock bank with one serial modulo lane per channel.
//
// channel  role    payload            transaction
// sample   sink    time_ms[47:0]      valid && ready
// result   source  fired_mask[3:0]    valid && ready
// cfg      sink    index[3:0], data   valid && ready (ready always high)
//
// Each item passes CALC (the elapsed times are formed and loaded into the lanes), DIV
// (the bit-serial modulo lanes, one dividend bit per cycle) and FIN (the anchors are
// updated). The next sample is taken in the cycle after the result is loaded.
// Reset clears intervals, anchors and the last time seen; no clearing pass.
// A result held by a stalled sink blocks only the final step of the following item.
`default_nettype none
module periodic_interval_clock_bank_core import picb_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	picb_cfg_if.sink  cfg,
	picb_in_if.sink   sample,
	picb_out_if.source result
);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CALC = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] last_seen_q;
	logic [IV_W-1:0]   interval_q [NUM_CHANNELS];
	logic [TIME_W-1:0] anchor_q [NUM_CHANNELS];
	logic [TIME_W-1:0] elapsed [NUM_CHANNELS];
	logic [IV_W-1:0]   rem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] fire_q;
	logic              out_valid_q;
	logic [MASK_W-1:0] mask_q;
	logic [MASK_W-1:0] mask_d;
	logic              fin_go;
	lane_ctrl_t        lane_ctrl;

	assign sample.ready = (state_q == ST_IDLE);
	assign cfg.ready    = 1'b1;
	assign result.valid      = out_valid_q;
	assign result.fired_mask = mask_q;

	assign lane_ctrl.load = (state_q == ST_CALC);
	assign lane_ctrl.step = (state_q == ST_DIV);
	assign fin_go = (state_q == ST_FIN) && (!out_valid_q || result.ready);

	for (genvar n = 0; n < NUM_CHANNELS; n++) begin : g_lane
		assign elapsed[n] = now_q - anchor_q[n];
		picb_lane u_lane (
			.clk     (clk),
			.ctrl    (lane_ctrl),
			.elapsed (elapsed[n]),
			.iv      (interval_q[n]),
			.rem     (rem[n])
		);
	end

	for (genvar m = 0; m < MASK_W; m++) begin : g_mask
		if (m < NUM_CHANNELS) begin : g_on
			assign mask_d[m] = fire_q[m];
		end else begin : g_off
			assign mask_d[m] = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			now_q <= sample.time_ms;
		end
		if (state_q == ST_CALC) begin
			for (int n = 0; n < NUM_CHANNELS; n++) begin
				fire_q[n] <= (interval_q[n] != '0) &&
					(elapsed[n] >= {{(TIME_W-IV_W){1'b0}}, interval_q[n]});
			end
		end
		if (fin_go) begin
			mask_q <= mask_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			last_seen_q <= '0;
			for (int n = 0; n < NUM_CHANNELS; n++) begin
				interval_q[n] <= '0;
				anchor_q[n]   <= '0;
			end
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			for (int n = 0; n < NUM_CHANNELS; n++) begin
				if (cfg.valid && (cfg.index == CFG_IDX_W'(n)) && (n < NUM_REGS)) begin
					interval_q[n] <= cfg.data;
					anchor_q[n]   <= last_seen_q;
				end else if (fin_go && fire_q[n]) begin
					anchor_q[n] <= now_q - {{(TIME_W-IV_W){1'b0}}, rem[n]};
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						last_seen_q <= sample.time_ms;
						state_q     <= ST_CALC;
					end
				end
				ST_CALC: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(TIME_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/picb_checker.sv
// Checker: port-level properties of the clock bank core, bound to the top level.
`default_nettype none
module picb_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic sample_valid,
	input wire logic sample_ready,
	input wire logic result_valid,
	input wire logic result_ready
);
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("sample taken while an item is in progress");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !$past(sample_ready))
		else $error("result raised without an item in progress");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped before transaction");
endmodule

bind periodic_interval_clock_bank_core picb_checker u_picb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample.valid),
	.sample_ready (sample.ready),
	.result_valid (result.valid),
	.result_ready (result.ready)
);
`default_nettype wire
